// ===== hw/rtl/ssw_pkg.sv =====
// ----------------------------------------------------------------------------
// ssw_pkg
// Shared types and constants for the structure-table walker.
// ----------------------------------------------------------------------------
package ssw_pkg;

	localparam int MAX_STRUCTS_DEF      = 256;
	localparam int MAX_STRING_COUNT_DEF = 16;

	localparam int TABLE_LEN_W = 27;
	localparam int LIMIT_W     = 9;
	localparam int CFG_DATA_W  = 27;
	localparam int CFG_IDX_W   = 2;

	localparam logic [TABLE_LEN_W-1:0] TABLE_CAP  = 27'h4000000;
	localparam logic [TABLE_LEN_W-1:0] OFFSET_MAX = 27'h7FFFFFF;
	localparam logic [LIMIT_W-1:0]     LIMIT_RST  = 9'd256;
	localparam logic [7:0]             END_TYPE   = 8'd127;

	localparam logic [CFG_IDX_W-1:0] REG_TABLE_LENGTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STRUCTURE_LIMIT = 2'd1;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_FORMATTED,
		PH_STR_FIRST,
		PH_STR_REST
	} phase_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_END     = 2'd1,
		ST_OVERRUN = 2'd2,
		ST_LIMIT   = 2'd3
	} walk_status_t;

	typedef struct packed {
		logic [7:0]   structure_type;
		logic [7:0]   formatted_length;
		logic [15:0]  structure_handle;
		logic [4:0]   strings_found;
		logic [7:0]   structure_index;
		walk_status_t walk_status;
	} result_t;

endpackage

// ===== hw/rtl/smbios_structure_walker.sv =====
// ----------------------------------------------------------------------------
// smbios_structure_walker
// Walks an SMBIOS structure table byte by byte and reports each structure.
// ----------------------------------------------------------------------------
// Input channel byte_valid/byte_ready carries one table byte and a restart
// flag per transfer; restart clears the walk before that byte is used.
// Output channel result_valid/result_ready carries one result per finished
// structure (double zero after the strings) or one status result when the
// walk stops on the end marker, a header overrunning table_length, or the
// structure limit. After a stop, bytes are taken and dropped until restart.
// Configuration: cfg_write with cfg_index 0 sets table_length, index 1
// sets structure_limit; write only while the block is idle.
// Path: a byte goes into an input register, the walk state is stepped
// from that register and any result lands in the output register, which
// drives result_valid.
// Throughput: one byte per cycle, limited only by the output register.
// A stalled receiver holds the result; the input register still takes one
// more byte, then byte_ready drops until the result is taken.
// Reset clears the walk state, sets table_length to 0 and
// structure_limit to 256.
// ----------------------------------------------------------------------------
module smbios_structure_walker #(
	parameter int MAX_STRUCTS      = ssw_pkg::MAX_STRUCTS_DEF,
	parameter int MAX_STRING_COUNT = ssw_pkg::MAX_STRING_COUNT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [ssw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ssw_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              byte_valid,
	output logic                              byte_ready,
	input  logic [7:0]                        table_byte,
	input  logic                              restart,
	output logic                              result_valid,
	input  logic                              result_ready,
	output logic [7:0]                        structure_type,
	output logic [7:0]                        formatted_length,
	output logic [15:0]                       structure_handle,
	output logic [4:0]                        strings_found,
	output logic [7:0]                        structure_index,
	output logic [1:0]                        walk_status
);

	logic [ssw_pkg::TABLE_LEN_W-1:0] table_length_q;
	logic [ssw_pkg::LIMIT_W-1:0]     structure_limit_q;

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             restart_s1;
	logic             step;
	logic             res_valid;
	ssw_pkg::result_t res;
	ssw_pkg::result_t result_q;
	logic             result_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_length_q    <= '0;
			structure_limit_q <= ssw_pkg::LIMIT_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				ssw_pkg::REG_TABLE_LENGTH:
					table_length_q <= cfg_data[ssw_pkg::TABLE_LEN_W-1:0];
				ssw_pkg::REG_STRUCTURE_LIMIT:
					structure_limit_q <= cfg_data[ssw_pkg::LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	assign step       = valid_s1 && (!result_valid_q || result_ready);
	assign byte_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			byte_s1    <= table_byte;
			restart_s1 <= restart;
		end
	end

	ssw_parser #(
		.MAX_STRUCTS      (MAX_STRUCTS),
		.MAX_STRING_COUNT (MAX_STRING_COUNT)
	) u_parser (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (step),
		.table_byte      (byte_s1),
		.restart         (restart_s1),
		.table_length    (table_length_q),
		.structure_limit (structure_limit_q),
		.res_valid       (res_valid),
		.res             (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (step) begin
			result_valid_q <= res_valid;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid)
			result_q <= res;
	end

	assign result_valid     = result_valid_q;
	assign structure_type   = result_q.structure_type;
	assign formatted_length = result_q.formatted_length;
	assign structure_handle = result_q.structure_handle;
	assign strings_found    = result_q.strings_found;
	assign structure_index  = result_q.structure_index;
	assign walk_status      = result_q.walk_status;

`ifndef NO_ASSERTIONS
	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!byte_ready |-> (result_valid && !result_ready))
		else $error("input stalled without a stalled result");

	a_end_marker_type: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && walk_status == ssw_pkg::ST_END) |->
		(structure_type == ssw_pkg::END_TYPE && structure_handle == 16'd0))
		else $error("end marker result carries wrong fields");

	a_status_fields_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (walk_status == ssw_pkg::ST_LIMIT ||
			walk_status == ssw_pkg::ST_OVERRUN)) |->
		(structure_type == 8'd0 && formatted_length == 8'd0 && strings_found == 5'd0))
		else $error("status result carries structure fields");
`endif

endmodule

// ===== hw/rtl/ssw_parser.sv =====
// ----------------------------------------------------------------------------
// ssw_parser
// Walk state and per-byte step logic; one byte is consumed per step.
// ----------------------------------------------------------------------------
module ssw_parser #(
	parameter int MAX_STRUCTS      = ssw_pkg::MAX_STRUCTS_DEF,
	parameter int MAX_STRING_COUNT = ssw_pkg::MAX_STRING_COUNT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                step,
	input  logic [7:0]                          table_byte,
	input  logic                                restart,
	input  logic [ssw_pkg::TABLE_LEN_W-1:0]     table_length,
	input  logic [ssw_pkg::LIMIT_W-1:0]         structure_limit,
	output logic                                res_valid,
	output ssw_pkg::result_t                    res
);

	localparam int DONE_W = $clog2(MAX_STRUCTS + 1);
	localparam int SC_W   = $clog2(MAX_STRING_COUNT + 1);
	localparam int LIM_W  = (DONE_W > ssw_pkg::LIMIT_W) ? DONE_W : ssw_pkg::LIMIT_W;
	localparam int OFS_W  = ssw_pkg::TABLE_LEN_W;

	ssw_pkg::phase_t  phase_q, cur_phase, phase_d;
	logic [OFS_W-1:0] offset_q, cur_offset, offset_d;
	logic [7:0]       ofs_q, cur_ofs, ofs_d;
	logic [7:0]       type_q, cur_type, type_d;
	logic [7:0]       len_q, cur_len, len_d;
	logic [15:0]      handle_q, cur_handle, handle_d;
	logic [SC_W-1:0]  strings_q, cur_strings, strings_d;
	logic             lz_q, cur_lz, lz_d;
	logic [DONE_W-1:0] done_q, cur_done, done_d;
	logic             fin_q, cur_fin, fin_d;

	logic [LIM_W-1:0]   lim_eff;
	logic [OFS_W-1:0]   len_eff;
	logic               limit_hit;
	logic               overrun;
	logic [SC_W-1:0]    strings_inc;

	// restart clears the walk before this byte is taken
	always_comb begin
		cur_phase   = restart ? ssw_pkg::PH_HEADER : phase_q;
		cur_offset  = restart ? '0 : offset_q;
		cur_ofs     = restart ? '0 : ofs_q;
		cur_type    = restart ? '0 : type_q;
		cur_len     = restart ? '0 : len_q;
		cur_handle  = restart ? '0 : handle_q;
		cur_strings = restart ? '0 : strings_q;
		cur_lz      = restart ? 1'b0 : lz_q;
		cur_done    = restart ? '0 : done_q;
		cur_fin     = restart ? 1'b0 : fin_q;
	end

	always_comb begin
		lim_eff = (LIM_W'(structure_limit) > LIM_W'(MAX_STRUCTS)) ?
			LIM_W'(MAX_STRUCTS) : LIM_W'(structure_limit);
		len_eff = (table_length > ssw_pkg::TABLE_CAP) ? ssw_pkg::TABLE_CAP : table_length;
		limit_hit = LIM_W'(cur_done) >= lim_eff;
		overrun   = ({1'b0, cur_offset} + (OFS_W+1)'(4)) > {1'b0, len_eff};
		strings_inc = (cur_strings < SC_W'(MAX_STRING_COUNT)) ?
			cur_strings + SC_W'(1) : cur_strings;
	end

	// next phase
	always_comb begin
		phase_d = cur_phase;
		if (!cur_fin) begin
			unique case (cur_phase)
				ssw_pkg::PH_HEADER: begin
					if (cur_ofs == 8'd3)
						phase_d = (cur_len > 8'd4) ? ssw_pkg::PH_FORMATTED :
							ssw_pkg::PH_STR_FIRST;
				end
				ssw_pkg::PH_FORMATTED: begin
					if (cur_ofs + 8'd1 >= cur_len)
						phase_d = ssw_pkg::PH_STR_FIRST;
				end
				ssw_pkg::PH_STR_FIRST: phase_d = ssw_pkg::PH_STR_REST;
				ssw_pkg::PH_STR_REST: begin
					if (table_byte == 8'd0 && cur_lz)
						phase_d = ssw_pkg::PH_HEADER;
				end
				default: phase_d = ssw_pkg::PH_HEADER;
			endcase
		end
	end

	// data path and result
	always_comb begin
		offset_d  = cur_offset;
		ofs_d     = cur_ofs;
		type_d    = cur_type;
		len_d     = cur_len;
		handle_d  = cur_handle;
		strings_d = cur_strings;
		lz_d      = cur_lz;
		done_d    = cur_done;
		fin_d     = cur_fin;
		res_valid = 1'b0;
		res       = '0;
		res.structure_index = 8'(cur_done);
		if (!cur_fin) begin
			if (cur_offset < ssw_pkg::OFFSET_MAX)
				offset_d = cur_offset + OFS_W'(1);
			unique case (cur_phase)
				ssw_pkg::PH_HEADER: begin
					if (cur_ofs == 8'd0) begin
						if (limit_hit) begin
							res_valid       = 1'b1;
							res.walk_status = ssw_pkg::ST_LIMIT;
							fin_d           = 1'b1;
						end else if (overrun) begin
							res_valid       = 1'b1;
							res.walk_status = ssw_pkg::ST_OVERRUN;
							fin_d           = 1'b1;
						end else if (table_byte == ssw_pkg::END_TYPE) begin
							res_valid          = 1'b1;
							res.structure_type = ssw_pkg::END_TYPE;
							res.walk_status    = ssw_pkg::ST_END;
							fin_d              = 1'b1;
						end else begin
							type_d    = table_byte;
							len_d     = '0;
							handle_d  = '0;
							strings_d = '0;
							lz_d      = 1'b0;
							ofs_d     = 8'd1;
						end
					end else begin
						case (cur_ofs)
							8'd1:    len_d = table_byte;
							8'd2:    handle_d = {8'd0, table_byte};
							default: handle_d = {table_byte, cur_handle[7:0]};
						endcase
						ofs_d = cur_ofs + 8'd1;
					end
				end
				ssw_pkg::PH_FORMATTED: ofs_d = cur_ofs + 8'd1;
				ssw_pkg::PH_STR_FIRST: begin
					if (table_byte == 8'd0) begin
						lz_d = 1'b1;
					end else begin
						strings_d = strings_inc;
						lz_d      = 1'b0;
					end
				end
				ssw_pkg::PH_STR_REST: begin
					if (table_byte == 8'd0) begin
						if (cur_lz) begin
							res_valid            = 1'b1;
							res.structure_type   = cur_type;
							res.formatted_length = cur_len;
							res.structure_handle = cur_handle;
							res.strings_found    = 5'(cur_strings);
							res.walk_status      = ssw_pkg::ST_DONE;
							done_d               = cur_done + DONE_W'(1);
							ofs_d                = '0;
							lz_d                 = 1'b0;
						end else begin
							lz_d = 1'b1;
						end
					end else begin
						if (cur_lz)
							strings_d = strings_inc;
						lz_d = 1'b0;
					end
				end
				default: fin_d = cur_fin;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= ssw_pkg::PH_HEADER;
			offset_q  <= '0;
			ofs_q     <= '0;
			type_q    <= '0;
			len_q     <= '0;
			handle_q  <= '0;
			strings_q <= '0;
			lz_q      <= 1'b0;
			done_q    <= '0;
			fin_q     <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_d;
			offset_q  <= offset_d;
			ofs_q     <= ofs_d;
			type_q    <= type_d;
			len_q     <= len_d;
			handle_q  <= handle_d;
			strings_q <= strings_d;
			lz_q      <= lz_d;
			done_q    <= done_d;
			fin_q     <= fin_d;
		end
	end

endmodule

// ===== test/smbios_structure_walker_test.sv =====
// ----------------------------------------------------------------------------
// smbios_structure_walker_test
// Self-checking bench for the SMBIOS structure-table walker.
// ----------------------------------------------------------------------------
// A short table of directed bytes and register writes opens the run. After it
// come random tables built from well-formed structures with random content,
// mixed with noise bytes and restarts in the middle of a table. Each phase
// writes the registers while the block is idle. A bench-side model of the
// walk predicts each report but where a directed row carries its own. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module smbios_structure_walker_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1250;
	localparam int CYCLE_LIMIT  = 800000;
	localparam int DRAIN_CYCLES = 6;
	localparam logic [ssw_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam ssw_pkg::result_t NO_REPORT = '0;

	typedef enum bit {ROW_BYTE, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t                      kind;
		logic [ssw_pkg::CFG_IDX_W-1:0]  index;
		logic [ssw_pkg::CFG_DATA_W-1:0] data;
		logic                           restart;
		bit                             fixed;
		ssw_pkg::result_t               report;
	} row_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_write;
	logic [ssw_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [ssw_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                           byte_valid;
	logic                           byte_ready;
	logic [7:0]                     table_byte;
	logic                           restart;
	logic                           result_valid;
	logic                           result_ready;
	logic [7:0]                     structure_type;
	logic [7:0]                     formatted_length;
	logic [15:0]                    structure_handle;
	logic [4:0]                     strings_found;
	logic [7:0]                     structure_index;
	logic [1:0]                     walk_status;

	// walk model state
	logic [ssw_pkg::TABLE_LEN_W-1:0] m_table_length;
	logic [ssw_pkg::LIMIT_W-1:0]     m_structure_limit;
	ssw_pkg::phase_t                 m_phase;
	logic [ssw_pkg::TABLE_LEN_W-1:0] m_offset;
	int                              m_pos;
	logic [7:0]                      m_type;
	logic [7:0]                      m_length;
	logic [15:0]                     m_handle;
	logic [4:0]                      m_strings;
	bit                              m_zero;
	int                              m_done;
	bit                              m_stopped;

	ssw_pkg::result_t pending_reports[$];
	int      failures    = 0;
	int      sent_bytes  = 0;
	bit      calm        = 1'b0;
	bit      fresh_table = 1'b0;

	row_t directed_steps [30] = '{
		'{ROW_BYTE, ssw_pkg::REG_TABLE_LENGTH, 27'h01, 1'b0, 1'b1,
			'{8'h00, 8'h00, 16'h0000, 5'd0, 8'd0, ssw_pkg::ST_OVERRUN}},
		'{ROW_CFG,  ssw_pkg::REG_TABLE_LENGTH, ssw_pkg::OFFSET_MAX, 1'b0, 1'b0, NO_REPORT},
		'{ROW_BYTE, ssw_pkg::REG_TABLE_LENGTH, 27'hFF, 1'b1, 1'b0, NO_REPORT},
		'{ROW_BYTE, ssw_pkg::REG_TABLE_LENGTH, 27'h02, 1'b0, 1'b0, NO_REPORT},
		'{ROW_BYTE, ssw_pkg::REG_TABLE_LENGTH, 27'hFF, 1'b0, 1'b0, NO_REPORT},
		'{ROW_BYTE, ssw_pkg::REG_TABLE_LENGTH, 27'h00, 1'b0, 1'b0, NO_REPORT},
		'{ROW_BYTE, ssw_pkg::REG_TABLE_LENGTH, 27'h00, 1'b0, 1'b0, NO_REPORT},
		'{ROW_BYTE, ssw_pkg::REG_TABLE_LENGTH, 27'h00, 1'b0, 1'b1,
			'{8'hFF, 8'h02, 16'h00FF, 5'd0, 8'd0, ssw_pkg::ST_DONE}},
		'{ROW_BYTE, ssw_pkg::REG_TABLE_LENGTH, 27'h00, 1'b0, 1'b0, NO_REPORT},
		'{ROW_BYTE, ssw_pkg::REG_TABLE_LENGTH, 27'h06, 1'b0, 1'b0, NO_REPORT},
		'{ROW_BYTE, ssw_pkg::REG_TABLE_LENGTH, 27'h34, 1'b0, 1'b0, NO_REPORT},
		'{ROW_BYTE, ssw_pkg::REG_TABLE_LENGTH, 27'h12, 1'b0, 1'b0, NO_REPORT},
		'{ROW_BYTE, ssw_pkg::REG_TABLE_LENGTH, 27'h00, 1'b0, 1'b0, NO_REPORT},
		'{ROW_BYTE, ssw_pkg::REG_TABLE_LENGTH, 27'hFF, 1'b0, 1'b0, NO_REPORT},
		'{ROW_BYTE, ssw_pkg::REG_TABLE_LENGTH, 27'h41, 1'b0, 1'b0, NO_REPORT},
		'{ROW_BYTE, ssw_pkg::REG_TABLE_LENGTH, 27'h00, 1'b0, 1'b0, NO_REPORT},
		'{ROW_BYTE, ssw_pkg::REG_TABLE_LENGTH, 27'h80, 1'b0, 1'b0, NO_REPORT},
		'{ROW_BYTE, ssw_pkg::REG_TABLE_LENGTH, 27'h00, 1'b0, 1'b0, NO_REPORT},
		'{ROW_BYTE, ssw_pkg::REG_TABLE_LENGTH, 27'h00, 1'b0, 1'b0, NO_REPORT},
		'{ROW_BYTE, ssw_pkg::REG_TABLE_LENGTH, 27'h01, 1'b0, 1'b0, NO_REPORT},
		'{ROW_BYTE, ssw_pkg::REG_TABLE_LENGTH, 27'h04, 1'b0, 1'b0, NO_REPORT},
		'{ROW_BYTE, ssw_pkg::REG_TABLE_LENGTH, 27'hFF, 1'b0, 1'b0, NO_REPORT},
		'{ROW_BYTE, ssw_pkg::REG_TABLE_LENGTH, 27'hFF, 1'b0, 1'b0, NO_REPORT},
		'{ROW_BYTE, ssw_pkg::REG_TABLE_LENGTH, 27'h00, 1'b0, 1'b0, NO_REPORT},
		'{ROW_BYTE, ssw_pkg::REG_TABLE_LENGTH, 27'h41, 1'b0, 1'b0, NO_REPORT},
		'{ROW_BYTE, ssw_pkg::REG_TABLE_LENGTH, 27'h00, 1'b0, 1'b0, NO_REPORT},
		'{ROW_BYTE, ssw_pkg::REG_TABLE_LENGTH, 27'h00, 1'b0, 1'b0, NO_REPORT},
		'{ROW_BYTE, ssw_pkg::REG_TABLE_LENGTH, 27'h7F, 1'b0, 1'b1,
			'{8'h7F, 8'h00, 16'h0000, 5'd0, 8'd3, ssw_pkg::ST_END}},
		'{ROW_CFG,  ssw_pkg::REG_STRUCTURE_LIMIT, 27'h000, 1'b0, 1'b0, NO_REPORT},
		'{ROW_BYTE, ssw_pkg::REG_TABLE_LENGTH, 27'h55, 1'b1, 1'b1,
			'{8'h00, 8'h00, 16'h0000, 5'd0, 8'd0, ssw_pkg::ST_LIMIT}}
	};

	smbios_structure_walker i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.byte_valid       (byte_valid),
		.byte_ready       (byte_ready),
		.table_byte       (table_byte),
		.restart          (restart),
		.result_valid     (result_valid),
		.result_ready     (result_ready),
		.structure_type   (structure_type),
		.formatted_length (formatted_length),
		.structure_handle (structure_handle),
		.strings_found    (strings_found),
		.structure_index  (structure_index),
		.walk_status      (walk_status)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void clear_walk_state();
		m_phase   = ssw_pkg::PH_HEADER;
		m_offset  = '0;
		m_pos     = 0;
		m_type    = '0;
		m_length  = '0;
		m_handle  = '0;
		m_strings = '0;
		m_zero    = 1'b0;
		m_done    = 0;
		m_stopped = 1'b0;
	endfunction

	// steps the walk by one byte, returns 1 when the byte ends a report
	function automatic bit walk_byte(input logic [7:0] b, input logic fresh,
		output ssw_pkg::result_t rep);
		int cap_len;
		int lim;
		bit made;
		made = 1'b0;
		rep  = '0;
		if (fresh)
			clear_walk_state();
		if (m_stopped)
			return 1'b0;
		rep.structure_index = m_done[7:0];
		case (m_phase)
			ssw_pkg::PH_HEADER: begin
				if (m_pos == 0) begin
					lim = (m_structure_limit > ssw_pkg::MAX_STRUCTS_DEF) ?
						ssw_pkg::MAX_STRUCTS_DEF : int'(m_structure_limit);
					cap_len = (m_table_length > ssw_pkg::TABLE_CAP) ?
						int'(ssw_pkg::TABLE_CAP) : int'(m_table_length);
					if (m_done >= lim) begin
						rep.walk_status = ssw_pkg::ST_LIMIT;
						m_stopped = 1'b1;
						return 1'b1;
					end
					if (int'(m_offset) + 4 > cap_len) begin
						rep.walk_status = ssw_pkg::ST_OVERRUN;
						m_stopped = 1'b1;
						return 1'b1;
					end
					if (b == ssw_pkg::END_TYPE) begin
						rep.structure_type = ssw_pkg::END_TYPE;
						rep.walk_status = ssw_pkg::ST_END;
						m_stopped = 1'b1;
						return 1'b1;
					end
					m_type    = b;
					m_length  = '0;
					m_handle  = '0;
					m_strings = '0;
					m_zero    = 1'b0;
				end else if (m_pos == 1) begin
					m_length = b;
				end else if (m_pos == 2) begin
					m_handle = {8'h00, b};
				end else begin
					m_handle[15:8] = b;
				end
				m_pos++;
				if (m_pos == 4)
					m_phase = (m_length > 4) ? ssw_pkg::PH_FORMATTED : ssw_pkg::PH_STR_FIRST;
			end
			ssw_pkg::PH_FORMATTED: begin
				m_pos++;
				if (m_pos >= m_length)
					m_phase = ssw_pkg::PH_STR_FIRST;
			end
			ssw_pkg::PH_STR_FIRST: begin
				if (b == 8'h00) begin
					m_zero = 1'b1;
				end else begin
					if (m_strings < ssw_pkg::MAX_STRING_COUNT_DEF)
						m_strings++;
					m_zero = 1'b0;
				end
				m_phase = ssw_pkg::PH_STR_REST;
			end
			default: begin
				if (b == 8'h00) begin
					if (m_zero) begin
						rep.structure_type   = m_type;
						rep.formatted_length = m_length;
						rep.structure_handle = m_handle;
						rep.strings_found    = m_strings;
						rep.walk_status      = ssw_pkg::ST_DONE;
						made    = 1'b1;
						m_done++;
						m_phase = ssw_pkg::PH_HEADER;
						m_pos   = 0;
						m_zero  = 1'b0;
					end else begin
						m_zero = 1'b1;
					end
				end else begin
					if (m_zero && m_strings < ssw_pkg::MAX_STRING_COUNT_DEF)
						m_strings++;
					m_zero = 1'b0;
				end
			end
		endcase
		if (m_offset != ssw_pkg::OFFSET_MAX)
			m_offset++;
		return made;
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic fresh, input bit fixed,
		input ssw_pkg::result_t want);
		int gap;
		ssw_pkg::result_t rep;
		gap = calm ? 0 : $urandom_range(0, 12);
		@(negedge clk);
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_valid <= 1'b1;
		table_byte <= b;
		restart    <= fresh;
		@(posedge clk);
		while (!byte_ready)
			@(posedge clk);
		if (walk_byte(b, fresh, rep) || fixed)
			pending_reports.push_back(fixed ? want : rep);
		sent_bytes++;
	endtask

	task automatic put_byte(input logic [7:0] b);
		send_byte(b, fresh_table, 1'b0, NO_REPORT);
		fresh_table = 1'b0;
	endtask

	task automatic write_reg(input logic [ssw_pkg::CFG_IDX_W-1:0] index,
		input logic [ssw_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(negedge clk);
		cfg_write <= 1'b0;
		if (index == ssw_pkg::REG_TABLE_LENGTH)
			m_table_length = data;
		else if (index == ssw_pkg::REG_STRUCTURE_LIMIT)
			m_structure_limit = data[ssw_pkg::LIMIT_W-1:0];
	endtask

	// idle the byte side until every report has come back
	task automatic settle();
		@(negedge clk);
		byte_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic emit_structure();
		int len;
		int nstr;
		logic [15:0] handle;
		case ($urandom_range(0, 7))
			0:       len = $urandom_range(41, 255);
			1, 2:    len = $urandom_range(13, 40);
			default: len = $urandom_range(0, 12);
		endcase
		handle = 16'($urandom);
		put_byte(8'($urandom));
		put_byte(8'(len));
		put_byte(handle[7:0]);
		put_byte(handle[15:8]);
		for (int i = 4; i < len; i++)
			put_byte(8'($urandom));
		nstr = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 4);
		// empty section, or a lone zero ahead of the text
		if (nstr == 0 || $urandom_range(0, 5) == 0)
			put_byte(8'h00);
		for (int s = 0; s < nstr; s++) begin
			repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(1, 255)));
			put_byte(8'h00);
		end
		put_byte(8'h00);
	endtask

	task automatic random_table();
		logic [ssw_pkg::TABLE_LEN_W-1:0] tbl_len;
		logic [ssw_pkg::LIMIT_W-1:0]     tbl_limit;
		int                              count;
		settle();
		case ($urandom_range(0, 7))
			0:       tbl_len = '0;
			1:       tbl_len = 27'($urandom_range(1, 8));
			2:       tbl_len = ssw_pkg::TABLE_CAP;
			3:       tbl_len = ssw_pkg::OFFSET_MAX;
			4:       tbl_len = 27'($urandom);
			default: tbl_len = 27'($urandom_range(9, 300));
		endcase
		case ($urandom_range(0, 7))
			0:       tbl_limit = '0;
			1:       tbl_limit = 9'd1;
			2:       tbl_limit = ssw_pkg::LIMIT_RST;
			3:       tbl_limit = '1;
			4:       tbl_limit = 9'($urandom);
			default: tbl_limit = 9'($urandom_range(2, 12));
		endcase
		write_reg(ssw_pkg::REG_TABLE_LENGTH, tbl_len);
		write_reg(ssw_pkg::REG_STRUCTURE_LIMIT,
			{{(ssw_pkg::CFG_DATA_W-ssw_pkg::LIMIT_W){1'b0}}, tbl_limit});
		if ($urandom_range(0, 9) == 0)
			write_reg(REG_SPARE, 27'($urandom));
		calm        = ($urandom_range(0, 3) == 0);
		fresh_table = 1'b1;
		count = $urandom_range(1, 10);
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 11) == 0)
				repeat ($urandom_range(1, 6)) put_byte(8'($urandom));
			if ($urandom_range(0, 15) == 0)
				fresh_table = 1'b1;
			emit_structure();
		end
		case ($urandom_range(0, 2))
			0:       put_byte(ssw_pkg::END_TYPE);
			1:       repeat ($urandom_range(1, 4)) put_byte(8'($urandom));
			default: ;
		endcase
	endtask

	task automatic check_report(input ssw_pkg::result_t got);
		ssw_pkg::result_t want;
		if (pending_reports.size() == 0) begin
			$error("unexpected result transfer: structure_type %0h walk_status %0d",
				got.structure_type, got.walk_status);
			failures++;
			return;
		end
		want = pending_reports.pop_front();
		if (got.structure_type !== want.structure_type) begin
			$error("structure_type: expected %0h, actual %0h",
				want.structure_type, got.structure_type);
			failures++;
		end
		if (got.formatted_length !== want.formatted_length) begin
			$error("formatted_length: expected %0h, actual %0h",
				want.formatted_length, got.formatted_length);
			failures++;
		end
		if (got.structure_handle !== want.structure_handle) begin
			$error("structure_handle: expected %0h, actual %0h",
				want.structure_handle, got.structure_handle);
			failures++;
		end
		if (got.strings_found !== want.strings_found) begin
			$error("strings_found: expected %0d, actual %0d",
				want.strings_found, got.strings_found);
			failures++;
		end
		if (got.structure_index !== want.structure_index) begin
			$error("structure_index: expected %0d, actual %0d",
				want.structure_index, got.structure_index);
			failures++;
		end
		if (got.walk_status !== want.walk_status) begin
			$error("walk_status: expected %0d, actual %0d",
				want.walk_status, got.walk_status);
			failures++;
		end
	endtask

	initial begin : report_sink
		int stall;
		ssw_pkg::result_t got;
		result_ready = 1'b0;
		forever begin
			stall = calm ? 0 : $urandom_range(0, 12);
			@(negedge clk);
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_ready <= 1'b1;
			@(posedge clk);
			while (!result_valid)
				@(posedge clk);
			got = {structure_type, formatted_length, structure_handle, strings_found,
				structure_index, walk_status};
			check_report(got);
		end
	end

	initial begin : watchdog
		int cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("smbios_structure_walker: mismatch");
		$finish;
	end

	initial begin : stimulus
		arst_n     = 1'b0;
		cfg_write  = 1'b0;
		cfg_index  = ssw_pkg::REG_TABLE_LENGTH;
		cfg_data   = '0;
		byte_valid = 1'b0;
		table_byte = '0;
		restart    = 1'b0;
		m_table_length    = '0;
		m_structure_limit = ssw_pkg::LIMIT_RST;
		clear_walk_state();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		foreach (directed_steps[i]) begin
			if (directed_steps[i].kind == ROW_CFG) begin
				settle();
				write_reg(directed_steps[i].index, directed_steps[i].data);
			end else begin
				send_byte(directed_steps[i].data[7:0], directed_steps[i].restart,
					directed_steps[i].fixed, directed_steps[i].report);
			end
		end
		while (sent_bytes < RANDOM_ITEMS)
			random_table();
		settle();
		if (failures == 0)
			$display("smbios_structure_walker: match");
		else
			$display("smbios_structure_walker: mismatch");
		$finish;
	end

endmodule
